>>> rtl/amgs_pkg.sv
package amgs_pkg;

    localparam int OP_W = 4;
    localparam int ST_W = 2;
    localparam int IN_W = 32;

    localparam logic [OP_W-1:0] OP_ADD_V   = 4'd0;
    localparam logic [OP_W-1:0] OP_SET_V   = 4'd1;
    localparam logic [OP_W-1:0] OP_GET_V   = 4'd2;
    localparam logic [OP_W-1:0] OP_ERASE_V = 4'd3;
    localparam logic [OP_W-1:0] OP_ADD_E   = 4'd4;
    localparam logic [OP_W-1:0] OP_SET_E   = 4'd5;
    localparam logic [OP_W-1:0] OP_GET_E   = 4'd6;
    localparam logic [OP_W-1:0] OP_ERASE_E = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR   = 4'd8;

    localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
    localparam logic [ST_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            self_edge;
    } cls_t;

endpackage

>>> rtl/amgs_ram.sv
module amgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/amgs_front.sv
module amgs_front #(
    parameter int IDX_W = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     hold,
    input  logic [amgs_pkg::OP_W-1:0] operation,
    input  logic [IDX_W-1:0]         row_index,
    input  logic [IDX_W-1:0]         column_index,
    input  logic [amgs_pkg::IN_W-1:0] data_value,
    output logic                     busy,
    output logic                     q_valid,
    input  logic                     q_pop,
    output amgs_pkg::cls_t           q_cls,
    output logic [IDX_W-1:0]         q_row,
    output logic [IDX_W-1:0]         q_col,
    output logic [amgs_pkg::IN_W-1:0] q_data
);

    amgs_pkg::cls_t            cls_reg  [2];
    logic [IDX_W-1:0]          row_reg  [2];
    logic [IDX_W-1:0]          col_reg  [2];
    logic [amgs_pkg::IN_W-1:0] data_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    amgs_pkg::cls_t cls_in;

    assign busy = (cnt_reg == 2'd2) || hold;
    assign push = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);

    always_comb
    begin
        cls_in.op = operation;
        cls_in.self_edge = (row_index == column_index);
    end

    always_comb
    begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cls_reg[wp_reg]  <= cls_in;
            row_reg[wp_reg]  <= row_index;
            col_reg[wp_reg]  <= column_index;
            data_reg[wp_reg] <= data_value;
        end
    end

    assign q_cls  = cls_reg[rp_reg];
    assign q_row  = row_reg[rp_reg];
    assign q_col  = col_reg[rp_reg];
    assign q_data = data_reg[rp_reg];

endmodule

>>> rtl/amgs_back.sv
module amgs_back #(
    parameter int MAX_VERTICES = 64,
    parameter int VALUE_BITS   = 32,
    parameter int IDX_W        = 6,
    parameter int CNT_W        = 7
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    output logic                      q_pop,
    input  amgs_pkg::cls_t            q_cls,
    input  logic [IDX_W-1:0]          q_row,
    input  logic [IDX_W-1:0]          q_col,
    input  logic [amgs_pkg::IN_W-1:0] q_data,
    output logic                      init_busy,
    output logic                      result_valid,
    output logic [amgs_pkg::ST_W-1:0] status,
    output logic [31:0]               read_value,
    output logic [CNT_W-1:0]          vertex_count,
    output logic                      is_empty
);

    localparam int EA_W = 2 * IDX_W;
    localparam int VB = VALUE_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_VERTICES - 1);
    localparam logic [63:0] MISS64 = 64'd1 << (VB - 1);
    localparam logic [31:0] MISS32 = MISS64[31:0];

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_RDV  = 4'd2;
    localparam logic [3:0] S_RDE  = 4'd3;
    localparam logic [3:0] S_ERR  = 4'd4;
    localparam logic [3:0] S_ERW  = 4'd5;
    localparam logic [3:0] S_ZROW = 4'd6;
    localparam logic [3:0] S_ZCOL = 4'd7;
    localparam logic [3:0] S_VSR  = 4'd8;
    localparam logic [3:0] S_VSW  = 4'd9;

    logic [3:0]             state_reg, state_next;
    logic [amgs_pkg::OP_W-1:0] op_reg, op_next;
    logic [IDX_W-1:0]       row_reg, row_next;
    logic [IDX_W-1:0]       col_reg, col_next;
    logic [VB-1:0]          data_reg, data_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [IDX_W-1:0]       n_reg, n_next;
    logic [IDX_W-1:0]       i_reg, i_next;
    logic [IDX_W-1:0]       j_reg, j_next;
    logic [EA_W-1:0]        sw_reg, sw_next;
    logic                   init_reg, init_next;
    logic                   rv_reg, rv_next;
    logic [amgs_pkg::ST_W-1:0] st_reg, st_next;
    logic [31:0]            rd_reg, rd_next;

    logic              v_we;
    logic [IDX_W-1:0]  v_waddr, v_raddr;
    logic [VB-1:0]     v_wdata, v_rdata;
    logic              e_we;
    logic [EA_W-1:0]   e_waddr, e_raddr;
    logic [VB-1:0]     e_wdata, e_rdata;

    logic              r_ok, c_ok, e_ok;
    logic [63:0]       q_ext;
    logic [VB-1:0]     q_val;
    logic [63:0]       v_ext, e_ext;
    logic [31:0]       v_rd32, e_rd32;
    logic [IDX_W-1:0]  si, sj;

    amgs_ram #(.WIDTH(VB), .DEPTH(MAX_VERTICES)) u_vram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    amgs_ram #(.WIDTH(VB), .DEPTH(1 << EA_W)) u_eram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    always_comb
    begin
        r_ok = (CNT_W'(q_row) < cnt_reg);
        c_ok = (CNT_W'(q_col) < cnt_reg);
        e_ok = r_ok && c_ok && !q_cls.self_edge;
        q_ext = {{32{q_data[31]}}, q_data};
        q_val = q_ext[VB-1:0];
        v_ext = 64'(v_rdata);
        e_ext = 64'(e_rdata);
        v_rd32 = v_ext[31:0];
        e_rd32 = e_ext[31:0];
        si = (i_reg < row_reg) ? i_reg : i_reg + 1'b1;
        sj = (j_reg < row_reg) ? j_reg : j_reg + 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        data_next  = data_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        sw_next    = sw_reg;
        init_next  = init_reg;
        rv_next    = 1'b0;
        st_next    = st_reg;
        rd_next    = rd_reg;
        q_pop      = 1'b0;
        v_we       = 1'b0;
        v_waddr    = row_reg;
        v_wdata    = data_reg;
        v_raddr    = row_reg;
        e_we       = 1'b0;
        e_waddr    = {row_reg, col_reg};
        e_wdata    = '0;
        e_raddr    = {row_reg, col_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    op_next   = q_cls.op;
                    row_next  = q_row;
                    col_next  = q_col;
                    data_next = q_val;
                    rv_next   = 1'b1;
                    st_next   = amgs_pkg::ST_DONE;
                    rd_next   = '0;
                    unique case (q_cls.op)
                        amgs_pkg::OP_ADD_V:
                        begin
                            if (cnt_reg == CNT_W'(MAX_VERTICES))
                            begin
                                st_next = amgs_pkg::ST_FULL;
                            end
                            else
                            begin
                                v_we     = 1'b1;
                                v_waddr  = cnt_reg[IDX_W-1:0];
                                v_wdata  = q_val;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        amgs_pkg::OP_SET_V:
                        begin
                            if (r_ok)
                            begin
                                v_we    = 1'b1;
                                v_waddr = q_row;
                                v_wdata = q_val;
                            end
                            else
                            begin
                                st_next = amgs_pkg::ST_IGNORED;
                            end
                        end
                        amgs_pkg::OP_GET_V:
                        begin
                            if (r_ok)
                            begin
                                v_raddr    = q_row;
                                rv_next    = 1'b0;
                                state_next = S_RDV;
                            end
                            else
                            begin
                                st_next = amgs_pkg::ST_IGNORED;
                                rd_next = MISS32;
                            end
                        end
                        amgs_pkg::OP_ERASE_V:
                        begin
                            if (r_ok)
                            begin
                                rv_next = 1'b0;
                                n_next  = IDX_W'(cnt_reg - 1'b1);
                                i_next  = '0;
                                j_next  = '0;
                                state_next = (cnt_reg == CNT_W'(1)) ? S_ZROW : S_ERR;
                            end
                            else
                            begin
                                st_next = amgs_pkg::ST_IGNORED;
                            end
                        end
                        amgs_pkg::OP_ADD_E, amgs_pkg::OP_ERASE_E:
                        begin
                            if (e_ok)
                            begin
                                e_we    = 1'b1;
                                e_waddr = {q_row, q_col};
                                e_wdata = (q_cls.op == amgs_pkg::OP_ADD_E) ? q_val : '0;
                            end
                            else
                            begin
                                st_next = amgs_pkg::ST_IGNORED;
                            end
                        end
                        amgs_pkg::OP_SET_E, amgs_pkg::OP_GET_E:
                        begin
                            if (e_ok)
                            begin
                                e_raddr    = {q_row, q_col};
                                rv_next    = 1'b0;
                                state_next = S_RDE;
                            end
                            else
                            begin
                                st_next = amgs_pkg::ST_IGNORED;
                                if (q_cls.op == amgs_pkg::OP_GET_E)
                                begin
                                    rd_next = MISS32;
                                end
                            end
                        end
                        amgs_pkg::OP_CLEAR:
                        begin
                            rv_next    = 1'b0;
                            sw_next    = '0;
                            state_next = S_CLR;
                        end
                        default:
                        begin
                            st_next = amgs_pkg::ST_IGNORED;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                e_we    = 1'b1;
                e_waddr = sw_reg;
                sw_next = sw_reg + 1'b1;
                if (sw_reg == {EA_W{1'b1}})
                begin
                    state_next = S_IDLE;
                    if (init_reg)
                    begin
                        init_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next = '0;
                        rv_next  = 1'b1;
                    end
                end
            end
            S_RDV:
            begin
                rv_next    = 1'b1;
                rd_next    = v_rd32;
                state_next = S_IDLE;
            end
            S_RDE:
            begin
                rv_next    = 1'b1;
                state_next = S_IDLE;
                if (e_rdata == '0)
                begin
                    st_next = amgs_pkg::ST_IGNORED;
                    if (op_reg == amgs_pkg::OP_GET_E)
                    begin
                        rd_next = MISS32;
                    end
                end
                else if (op_reg == amgs_pkg::OP_GET_E)
                begin
                    rd_next = e_rd32;
                end
                else
                begin
                    e_we    = 1'b1;
                    e_wdata = data_reg;
                end
            end
            S_ERR:
            begin
                e_raddr    = {si, sj};
                state_next = S_ERW;
            end
            S_ERW:
            begin
                e_we       = 1'b1;
                e_waddr    = {i_reg, j_reg};
                e_wdata    = e_rdata;
                state_next = S_ERR;
                if (j_reg == n_reg - 1'b1)
                begin
                    j_next = '0;
                    if (i_reg == n_reg - 1'b1)
                    begin
                        state_next = S_ZROW;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_ZROW:
            begin
                e_we    = 1'b1;
                e_waddr = {n_reg, j_reg};
                j_next  = j_reg + 1'b1;
                if (j_reg == LAST_IDX)
                begin
                    j_next     = '0;
                    state_next = S_ZCOL;
                end
            end
            S_ZCOL:
            begin
                e_we    = 1'b1;
                e_waddr = {j_reg, n_reg};
                j_next  = j_reg + 1'b1;
                if (j_reg == LAST_IDX)
                begin
                    j_next = '0;
                    i_next = row_reg;
                    if (row_reg == n_reg)
                    begin
                        cnt_next   = CNT_W'(n_reg);
                        rv_next    = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_VSR;
                    end
                end
            end
            S_VSR:
            begin
                v_raddr    = i_reg + 1'b1;
                state_next = S_VSW;
            end
            S_VSW:
            begin
                v_we    = 1'b1;
                v_waddr = i_reg;
                v_wdata = v_rdata;
                if (i_reg + 1'b1 == n_reg)
                begin
                    cnt_next   = CNT_W'(n_reg);
                    rv_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_VSR;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
            sw_reg    <= '0;
            init_reg  <= 1'b1;
            rv_reg    <= 1'b0;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sw_reg    <= sw_next;
            init_reg  <= init_next;
            rv_reg    <= rv_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        data_reg <= data_next;
        st_reg   <= st_next;
        rd_reg   <= rd_next;
    end

    assign init_busy    = init_reg;
    assign result_valid = rv_reg;
    assign status       = st_reg;
    assign read_value   = rd_reg;
    assign vertex_count = cnt_reg;
    assign is_empty     = (cnt_reg == '0);

endmodule

>>> rtl/adjacency_matrix_graph_store.sv
// Directed weighted graph store with an adjacency matrix. A command is taken when
// start is high and busy is low; each command gives exactly one result, shown for one
// cycle with result_valid high, which the receiver must take then. A two-entry command
// queue lets up to two commands wait while one executes. With the back end idle, a
// command passes from its queue register to the back end, which registers the result;
// vertex and edge reads and edge sets first pass through a memory read state. Clear
// sweeps the whole matrix memory, 2^(2*ceil(log2 MAX_VERTICES)) entries (4096 by
// default); erasing a vertex moves the remaining matrix entries through the single
// write port, each read then written, zeroes the last row and column and shifts later
// vertex values down. After reset it sweeps the matrix like a clear, holding busy high.
module adjacency_matrix_graph_store #(
    parameter int MAX_VERTICES = 64,
    parameter int VALUE_BITS   = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [3:0]                         operation,
    input  logic [$clog2(MAX_VERTICES)-1:0]    row_index,
    input  logic [$clog2(MAX_VERTICES)-1:0]    column_index,
    input  logic signed [31:0]                 data_value,
    output logic                               result_valid,
    output logic [1:0]                         status,
    output logic signed [31:0]                 read_value,
    output logic [$clog2(MAX_VERTICES+1)-1:0]  vertex_count,
    output logic                               is_empty
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    logic                      init_busy;
    logic                      q_valid;
    logic                      q_pop;
    amgs_pkg::cls_t            q_cls;
    logic [IDX_W-1:0]          q_row;
    logic [IDX_W-1:0]          q_col;
    logic [amgs_pkg::IN_W-1:0] q_data;
    logic [31:0]               rd_raw;

    amgs_front #(.IDX_W(IDX_W)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .hold         (init_busy),
        .operation    (operation),
        .row_index    (row_index),
        .column_index (column_index),
        .data_value   (data_value),
        .busy         (busy),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_cls        (q_cls),
        .q_row        (q_row),
        .q_col        (q_col),
        .q_data       (q_data)
    );

    amgs_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .VALUE_BITS   (VALUE_BITS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_cls        (q_cls),
        .q_row        (q_row),
        .q_col        (q_col),
        .q_data       (q_data),
        .init_busy    (init_busy),
        .result_valid (result_valid),
        .status       (status),
        .read_value   (rd_raw),
        .vertex_count (vertex_count),
        .is_empty     (is_empty)
    );

    assign read_value = signed'(rd_raw);

endmodule

>>> rtl/amgs_checker.sv
module amgs_checker #(
    parameter int MAX_VERTICES = 64
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              result_valid,
    input logic [1:0]                        status,
    input logic [$clog2(MAX_VERTICES+1)-1:0] vertex_count,
    input logic                              is_empty
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (is_empty == (vertex_count == '0)))
        else $error("is_empty disagrees with vertex_count");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == amgs_pkg::ST_FULL) |->
        (vertex_count == CNT_W'(MAX_VERTICES)))
        else $error("full status below capacity");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == amgs_pkg::ST_DONE || status == amgs_pkg::ST_IGNORED ||
                          status == amgs_pkg::ST_FULL))
        else $error("bad status code");

    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_count <= CNT_W'(MAX_VERTICES))
        else $error("vertex count above capacity");

endmodule

bind adjacency_matrix_graph_store amgs_checker #(.MAX_VERTICES(MAX_VERTICES)) u_amgs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .status       (status),
    .vertex_count (vertex_count),
    .is_empty     (is_empty)
);

>>> sim/tb_adjacency_matrix_graph_store.sv
module tb_adjacency_matrix_graph_store;

    localparam int NV = 64;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        logic [3:0]  op;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] data;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic [6:0]  count;
        logic        empty;
    } resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [3:0] operation = '0;
    logic [5:0] row_index = '0;
    logic [5:0] column_index = '0;
    logic signed [31:0] data_value = '0;
    logic result_valid;
    logic [1:0] status;
    logic signed [31:0] read_value;
    logic [6:0] vertex_count;
    logic is_empty;

    adjacency_matrix_graph_store DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .row_index(row_index), .column_index(column_index),
        .data_value(data_value), .result_valid(result_valid), .status(status),
        .read_value(read_value), .vertex_count(vertex_count), .is_empty(is_empty)
    );

    always #2 clk = ~clk;

    // graph shadow
    logic [31:0] vals [NV];
    logic [31:0] wts [NV][NV];
    int unsigned nverts;

    cmd_t pending_cmds[$];
    resp_t expected_resps[$];
    int errors = 0;
    bit hold_sender = 1'b0;
    int watchdog = 0;
    int unsigned accepted_cnt = 0;
    int unsigned sent_cnt = 0;

    function automatic resp_t apply_command(cmd_t c);
        resp_t r;
        int n;
        bit eok;
        r.status = amgs_pkg::ST_DONE;
        r.value = '0;
        eok = c.row < nverts && c.col < nverts && c.row != c.col;
        case (c.op)
            amgs_pkg::OP_ADD_V:
                if (nverts >= NV) r.status = amgs_pkg::ST_FULL;
                else
                begin
                    vals[nverts] = c.data;
                    nverts++;
                end
            amgs_pkg::OP_SET_V:
                if (c.row < nverts) vals[c.row] = c.data;
                else r.status = amgs_pkg::ST_IGNORED;
            amgs_pkg::OP_GET_V:
                if (c.row < nverts) r.value = vals[c.row];
                else
                begin
                    r.status = amgs_pkg::ST_IGNORED;
                    r.value = 32'h8000_0000;
                end
            amgs_pkg::OP_ERASE_V:
                if (c.row < nverts)
                begin
                    n = nverts - 1;
                    for (int i = 0; i < n; i++)
                        for (int j = 0; j < n; j++)
                            wts[i][j] = wts[i < c.row ? i : i + 1][j < c.row ? j : j + 1];
                    for (int j = 0; j < NV; j++)
                    begin
                        wts[n][j] = '0;
                        wts[j][n] = '0;
                    end
                    for (int i = c.row; i < n; i++) vals[i] = vals[i + 1];
                    vals[n] = '0;
                    nverts = n;
                end
                else r.status = amgs_pkg::ST_IGNORED;
            amgs_pkg::OP_ADD_E:
                if (eok) wts[c.row][c.col] = c.data;
                else r.status = amgs_pkg::ST_IGNORED;
            amgs_pkg::OP_SET_E:
                if (eok && wts[c.row][c.col] != 0) wts[c.row][c.col] = c.data;
                else r.status = amgs_pkg::ST_IGNORED;
            amgs_pkg::OP_GET_E:
                if (eok && wts[c.row][c.col] != 0) r.value = wts[c.row][c.col];
                else
                begin
                    r.status = amgs_pkg::ST_IGNORED;
                    r.value = 32'h8000_0000;
                end
            amgs_pkg::OP_ERASE_E:
                if (eok) wts[c.row][c.col] = '0;
                else r.status = amgs_pkg::ST_IGNORED;
            amgs_pkg::OP_CLEAR:
            begin
                foreach (vals[i]) vals[i] = '0;
                foreach (wts[i, j]) wts[i][j] = '0;
                nverts = 0;
            end
            default: r.status = amgs_pkg::ST_IGNORED;
        endcase
        r.count = nverts[6:0];
        r.empty = (nverts == 0);
        return r;
    endfunction

    function automatic cmd_t mk(logic [3:0] op, logic [5:0] r, logic [5:0] c, logic [31:0] d);
        cmd_t x;
        x.op = op;
        x.row = r;
        x.col = c;
        x.data = d;
        return x;
    endfunction

    // driver
    int gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && accepted_cnt == sent_cnt)
            begin
                // transfer happened at the last rising edge
                start <= 1'b0;
                gap = $urandom_range(0, 13);
                if ($urandom_range(0, 3) == 0) gap = 0;
            end
            else if (!start)
            begin
                if (gap > 0) gap--;
                else if (pending_cmds.size() > 0 && !(hold_sender && expected_resps.size() > 0))
                begin
                    cmd_t c;
                    c = pending_cmds.pop_front();
                    operation <= c.op;
                    row_index <= c.row;
                    column_index <= c.col;
                    data_value <= c.data;
                    start <= 1'b1;
                    sent_cnt++;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid) watchdog <= 0;
            else watchdog <= watchdog + 1;
            if (start && !busy)
            begin
                cmd_t c;
                c = mk(operation, row_index, column_index, data_value);
                expected_resps.push_back(apply_command(c));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (result_valid)
            begin
                resp_t e;
                if (expected_resps.size() == 0)
                begin
                    $error("unexpected result");
                    errors++;
                end
                else
                begin
                    e = expected_resps.pop_front();
                    if (status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, status);
                        errors++;
                    end
                    if (read_value !== e.value)
                    begin
                        $error("read_value exp %h got %h", e.value, read_value);
                        errors++;
                    end
                    if (vertex_count !== e.count)
                    begin
                        $error("vertex_count exp %0d got %0d", e.count, vertex_count);
                        errors++;
                    end
                    if (is_empty !== e.empty)
                    begin
                        $error("is_empty exp %0d got %0d", e.empty, is_empty);
                        errors++;
                    end
                end
            end
            if (watchdog >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_data();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    function automatic cmd_t rand_cmd(int unsigned nv);
        cmd_t c;
        int unsigned sel;
        int unsigned lim;
        lim = (nv > 0) ? nv - 1 : 0;
        sel = $urandom_range(0, 99);
        c.data = rand_data();
        c.row = 6'($urandom_range(0, lim));
        c.col = 6'($urandom_range(0, lim));
        if (sel < 22) c.op = amgs_pkg::OP_ADD_V;
        else if (sel < 30) c.op = amgs_pkg::OP_SET_V;
        else if (sel < 38) c.op = amgs_pkg::OP_GET_V;
        else if (sel < 43) c.op = amgs_pkg::OP_ERASE_V;
        else if (sel < 58) c.op = amgs_pkg::OP_ADD_E;
        else if (sel < 66) c.op = amgs_pkg::OP_SET_E;
        else if (sel < 80) c.op = amgs_pkg::OP_GET_E;
        else if (sel < 85) c.op = amgs_pkg::OP_ERASE_E;
        else if (sel < 86) c.op = amgs_pkg::OP_CLEAR;
        else if (sel < 89) c.op = 4'($urandom_range(9, 15));
        else
        begin
            // out of range noise
            c.op = 4'($urandom_range(0, 8));
            c.row = 6'($urandom());
            c.col = 6'($urandom());
        end
        return c;
    endfunction

    initial
    begin
        int unsigned nv_est;
        int stall;
        cmd_t c;
        foreach (vals[i]) vals[i] = '0;
        foreach (wts[i, j]) wts[i][j] = '0;
        nverts = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        pending_cmds.push_back(mk(amgs_pkg::OP_GET_V, 6'd0, 6'd0, 32'h0));
        pending_cmds.push_back(mk(amgs_pkg::OP_ERASE_V, 6'd63, 6'd0, 32'h0));
        pending_cmds.push_back(mk(amgs_pkg::OP_ADD_V, 6'd0, 6'd0, 32'h8000_0000));
        pending_cmds.push_back(mk(amgs_pkg::OP_ADD_V, 6'd0, 6'd0, 32'h7FFF_FFFF));
        pending_cmds.push_back(mk(amgs_pkg::OP_ADD_V, 6'd0, 6'd0, 32'hFFFF_FFFF));
        pending_cmds.push_back(mk(amgs_pkg::OP_SET_V, 6'd1, 6'd0, 32'h1234_5678));
        pending_cmds.push_back(mk(amgs_pkg::OP_SET_V, 6'd63, 6'd0, 32'h1));
        pending_cmds.push_back(mk(amgs_pkg::OP_GET_V, 6'd1, 6'd0, 32'h0));
        pending_cmds.push_back(mk(amgs_pkg::OP_ADD_E, 6'd0, 6'd1, 32'h8000_0000));
        pending_cmds.push_back(mk(amgs_pkg::OP_ADD_E, 6'd1, 6'd2, 32'h7FFF_FFFF));
        pending_cmds.push_back(mk(amgs_pkg::OP_ADD_E, 6'd2, 6'd0, 32'h0));
        pending_cmds.push_back(mk(amgs_pkg::OP_ADD_E, 6'd1, 6'd1, 32'h5));
        pending_cmds.push_back(mk(amgs_pkg::OP_SET_E, 6'd2, 6'd0, 32'h9));
        pending_cmds.push_back(mk(amgs_pkg::OP_SET_E, 6'd0, 6'd1, 32'hFFFF_FFFF));
        pending_cmds.push_back(mk(amgs_pkg::OP_GET_E, 6'd0, 6'd1, 32'h0));
        pending_cmds.push_back(mk(amgs_pkg::OP_GET_E, 6'd2, 6'd0, 32'h0));
        pending_cmds.push_back(mk(amgs_pkg::OP_GET_E, 6'd63, 6'd63, 32'h0));
        pending_cmds.push_back(mk(amgs_pkg::OP_ERASE_E, 6'd2, 6'd0, 32'h0));
        pending_cmds.push_back(mk(amgs_pkg::OP_ERASE_E, 6'd0, 6'd0, 32'h0));
        pending_cmds.push_back(mk(amgs_pkg::OP_ERASE_V, 6'd0, 6'd0, 32'h0));
        pending_cmds.push_back(mk(amgs_pkg::OP_GET_E, 6'd0, 6'd1, 32'h0));
        pending_cmds.push_back(mk(4'd15, 6'd0, 6'd0, 32'h0));
        pending_cmds.push_back(mk(amgs_pkg::OP_CLEAR, 6'd0, 6'd0, 32'h0));
        while (pending_cmds.size() > 0 || start || expected_resps.size() > 0) @(posedge clk);

        // fill to capacity, then one more add
        for (int i = 0; i < NV + 1; i++)
            pending_cmds.push_back(mk(amgs_pkg::OP_ADD_V, 6'd0, 6'd0, $urandom()));
        pending_cmds.push_back(mk(amgs_pkg::OP_ADD_E, 6'd63, 6'd62, 32'h77));
        pending_cmds.push_back(mk(amgs_pkg::OP_ADD_E, 6'd62, 6'd63, 32'h88));
        pending_cmds.push_back(mk(amgs_pkg::OP_GET_V, 6'd63, 6'd0, 32'h0));
        pending_cmds.push_back(mk(amgs_pkg::OP_ERASE_V, 6'd63, 6'd0, 32'h0));
        pending_cmds.push_back(mk(amgs_pkg::OP_GET_E, 6'd62, 6'd63, 32'h0));
        pending_cmds.push_back(mk(amgs_pkg::OP_ERASE_V, 6'd0, 6'd0, 32'h0));
        pending_cmds.push_back(mk(amgs_pkg::OP_CLEAR, 6'd0, 6'd0, 32'h0));
        while (pending_cmds.size() > 0 || start || expected_resps.size() > 0) @(posedge clk);

        // random, small graphs mostly
        nv_est = 0;
        for (int k = 0; k < 45; k++)
        begin
            c = rand_cmd(nv_est > 0 ? nv_est : 1);
            if (nv_est > 12 && c.op == amgs_pkg::OP_ADD_V) c.op = amgs_pkg::OP_GET_E;
            if (c.op == amgs_pkg::OP_ADD_V) nv_est++;
            if (c.op == amgs_pkg::OP_ERASE_V && c.row < nv_est && nv_est > 0) nv_est--;
            if (c.op == amgs_pkg::OP_CLEAR) nv_est = 0;
            pending_cmds.push_back(c);
            if (k == 22)
            begin
                while (pending_cmds.size() > 0 || start) @(posedge clk);
                hold_sender = 1'b1;
                while (expected_resps.size() > 0) @(posedge clk);
                hold_sender = 1'b0;
            end
        end
        while (pending_cmds.size() > 0 || start) @(posedge clk);
        stall = 0;
        while (expected_resps.size() > 0 && stall < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            stall++;
        end
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_resps.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> files.f
rtl/amgs_pkg.sv
rtl/amgs_ram.sv
rtl/amgs_front.sv
rtl/amgs_back.sv
rtl/adjacency_matrix_graph_store.sv
rtl/amgs_checker.sv
sim/tb_adjacency_matrix_graph_store.sv
